// ----- hw/rtl/ipt_pkg.sv -----
// shared types and codes for the interval pool time filter
package ipt_pkg;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_FINISH = 2'd1;
  localparam logic [1:0] CMD_CHECK  = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POOL_FULL = 2'd1;
  localparam logic [1:0] ST_SET_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] interval_begin;
    logic [63:0] interval_end;
    logic [63:0] time_value;
  } in_item_t;

  typedef struct packed {
    logic        in_range;
    logic [63:0] next_begin;
    logic [63:0] next_end;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [63:0] begin_v;
    logic [63:0] end_v;
  } entry_t;

  typedef enum logic [1:0] {
    TK_FIND  = 2'd0,
    TK_PLACE = 2'd1,
    TK_ERASE = 2'd2
  } tok_kind_t;

  // token that travels down the end-value cells
  typedef struct packed {
    logic        vld;
    tok_kind_t   kind;
    logic [63:0] value;
    logic        hit;
  } tok_t;

endpackage

// ----- hw/rtl/ipt_cell.sv -----
// one slot of the open end-value set, passes a token to its neighbour each cycle
module ipt_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         clr,
  input  ipt_pkg::tok_t tok_i,
  output ipt_pkg::tok_t tok_o
);
  import ipt_pkg::*;

  logic        valid_r, valid_nxt;
  logic [63:0] value_r, value_nxt;
  tok_t        tok_r, tok_nxt;
  logic        match;

  assign match = valid_r && (value_r == tok_i.value);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    tok_nxt   = tok_i;
    if (tok_i.vld) begin
      case (tok_i.kind)
        TK_FIND: begin
          if (match) tok_nxt.hit = 1'b1;
        end
        TK_PLACE: begin
          // first free slot takes the value
          if (!tok_i.hit && !valid_r) begin
            valid_nxt   = 1'b1;
            value_nxt   = tok_i.value;
            tok_nxt.hit = 1'b1;
          end
        end
        TK_ERASE: begin
          if (match) begin
            valid_nxt   = 1'b0;
            tok_nxt.hit = 1'b1;
          end
        end
        default: tok_nxt = tok_i;
      endcase
    end
    if (clr) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      tok_r.vld <= tok_nxt.vld;
    end
    value_r     <= value_nxt;
    tok_r.kind  <= tok_nxt.kind;
    tok_r.value <= tok_nxt.value;
    tok_r.hit   <= tok_nxt.hit;
  end

  assign tok_o = tok_r;

endmodule

// ----- hw/rtl/interval_pool_time_filter.sv -----
// top level: interval pool in a memory, sequencer, and row of end-value cells
// add reads the entry at the cursor if there is one, then widens it or appends; clear
//   empties the pool and end set; finish sorts the pool by insertion on begin, shifting
//   larger entries up; check walks entries with begin at or below the time value, sending
//   a find token per entry and a place token for a new end, then an erase; one item at a time
// synchronous reset clears counts, cursor and set valid bits; pool contents undefined
module interval_pool_time_filter #(
  parameter int POOL_DEPTH     = 256,
  parameter int OPEN_SET_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ipt_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ipt_pkg::out_item_t  out_item
);
  import ipt_pkg::*;

  localparam int PW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int SW = $clog2(OPEN_SET_DEPTH + 1);

  typedef enum logic [12:0] {
    S_IDLE      = 13'h0001,
    S_ADD_CMP   = 13'h0002,
    S_SRT_RD    = 13'h0004,
    S_SRT_KEY   = 13'h0008,
    S_SRT_CMP   = 13'h0010,
    S_SRT_PUT   = 13'h0020,
    S_CHK_RD    = 13'h0040,
    S_CHK_CMP   = 13'h0080,
    S_CHK_FIND  = 13'h0100,
    S_CHK_PLACE = 13'h0200,
    S_CHK_ERASE = 13'h0400,
    S_OUT_LD    = 13'h0800,
    S_DONE      = 13'h1000
  } state_t;

  state_t          state_r, state_nxt;
  in_item_t        item_r, item_nxt;
  out_item_t       res_r, res_nxt;
  out_item_t       out_item_r, out_item_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [CW-1:0]   cursor_r, cursor_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [SW-1:0]   set_cnt_r, set_cnt_nxt;
  entry_t          key_r, key_nxt;

  entry_t          mem [POOL_DEPTH];
  entry_t          rd_q_r;
  logic            we, rd_en;
  logic [PW-1:0]   wa, ra;
  entry_t          wd;

  logic            set_clr;
  tok_t            tok_in;
  tok_t            tok_chain [OPEN_SET_DEPTH+1];
  tok_t            tok_out;

  logic [CW-1:0]   cursor_inc, count_inc, i_inc, i_dec, j_dec, j_dec2;
  logic            at_entry, pool_full, set_full;

  assign cursor_inc = cursor_r + 1'b1;
  assign count_inc  = count_r + 1'b1;
  assign i_inc      = i_r + 1'b1;
  assign i_dec      = i_r - 1'b1;
  assign j_dec      = j_r - 1'b1;
  assign j_dec2     = j_r - 2'd2;
  assign at_entry   = cursor_r < count_r;
  assign pool_full  = count_r == CW'(POOL_DEPTH);
  assign set_full   = set_cnt_r == SW'(OPEN_SET_DEPTH);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    cursor_nxt    = cursor_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    set_cnt_nxt   = set_cnt_r;
    key_nxt       = key_r;
    we            = 1'b0;
    wa            = '0;
    wd            = '0;
    rd_en         = 1'b0;
    ra            = '0;
    set_clr       = 1'b0;
    tok_in        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_item;
          res_nxt  = '0;
          case (in_item.cmd)
            CMD_ADD: begin
              if (at_entry) begin
                rd_en     = 1'b1;
                ra        = cursor_r[PW-1:0];
                state_nxt = S_ADD_CMP;
              end else begin
                if (pool_full) begin
                  res_nxt.status = ST_POOL_FULL;
                end else begin
                  we                 = 1'b1;
                  wa                 = count_r[PW-1:0];
                  wd.begin_v         = in_item.interval_begin;
                  wd.end_v           = in_item.interval_end;
                  cursor_nxt         = count_r;
                  count_nxt          = count_inc;
                  res_nxt.next_begin = in_item.interval_begin;
                  res_nxt.next_end   = in_item.interval_end;
                end
                state_nxt = S_DONE;
              end
            end
            CMD_FINISH: begin
              cursor_nxt  = '0;
              set_clr     = 1'b1;
              set_cnt_nxt = '0;
              rd_en       = 1'b1;
              if (count_r > CW'(1)) begin
                i_nxt     = CW'(1);
                ra        = PW'(1);
                state_nxt = S_SRT_KEY;
              end else begin
                ra        = '0;
                state_nxt = S_OUT_LD;
              end
            end
            CMD_CHECK: state_nxt = S_CHK_RD;
            CMD_CLEAR: begin
              count_nxt   = '0;
              cursor_nxt  = '0;
              set_clr     = 1'b1;
              set_cnt_nxt = '0;
              state_nxt   = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_ADD_CMP: begin
        if (item_r.interval_begin > rd_q_r.end_v) begin
          if (pool_full) begin
            res_nxt.status     = ST_POOL_FULL;
            res_nxt.next_begin = rd_q_r.begin_v;
            res_nxt.next_end   = rd_q_r.end_v;
          end else begin
            we                 = 1'b1;
            wa                 = count_r[PW-1:0];
            wd.begin_v         = item_r.interval_begin;
            wd.end_v           = item_r.interval_end;
            cursor_nxt         = count_r;
            count_nxt          = count_inc;
            res_nxt.next_begin = item_r.interval_begin;
            res_nxt.next_end   = item_r.interval_end;
          end
        end else begin
          // widen the entry at the cursor
          wd = rd_q_r;
          if (item_r.interval_begin < rd_q_r.begin_v) wd.begin_v = item_r.interval_begin;
          if (item_r.interval_end > rd_q_r.end_v) wd.end_v = item_r.interval_end;
          we                 = 1'b1;
          wa                 = cursor_r[PW-1:0];
          res_nxt.next_begin = wd.begin_v;
          res_nxt.next_end   = wd.end_v;
        end
        state_nxt = S_DONE;
      end

      S_SRT_RD: begin
        rd_en     = 1'b1;
        ra        = i_r[PW-1:0];
        state_nxt = S_SRT_KEY;
      end

      S_SRT_KEY: begin
        key_nxt   = rd_q_r;
        j_nxt     = i_r;
        rd_en     = 1'b1;
        ra        = i_dec[PW-1:0];
        state_nxt = S_SRT_CMP;
      end

      S_SRT_CMP: begin
        if (rd_q_r.begin_v > key_r.begin_v) begin
          // shift the larger entry up one place
          we    = 1'b1;
          wa    = j_r[PW-1:0];
          wd    = rd_q_r;
          j_nxt = j_dec;
          if (j_dec == '0) begin
            state_nxt = S_SRT_PUT;
          end else begin
            rd_en = 1'b1;
            ra    = j_dec2[PW-1:0];
          end
        end else begin
          we = 1'b1;
          wa = j_r[PW-1:0];
          wd = key_r;
          if (i_inc < count_r) begin
            i_nxt     = i_inc;
            state_nxt = S_SRT_RD;
          end else begin
            rd_en     = 1'b1;
            ra        = '0;
            state_nxt = S_OUT_LD;
          end
        end
      end

      S_SRT_PUT: begin
        we = 1'b1;
        wa = j_r[PW-1:0];
        wd = key_r;
        if (i_inc < count_r) begin
          i_nxt     = i_inc;
          state_nxt = S_SRT_RD;
        end else begin
          // the key lands at the front, so it is the entry at the cursor
          res_nxt.next_begin = key_r.begin_v;
          res_nxt.next_end   = key_r.end_v;
          state_nxt          = S_DONE;
        end
      end

      S_CHK_RD: begin
        if (at_entry) begin
          rd_en     = 1'b1;
          ra        = cursor_r[PW-1:0];
          state_nxt = S_CHK_CMP;
        end else begin
          res_nxt.in_range = set_cnt_r != '0;
          tok_in.vld       = 1'b1;
          tok_in.kind      = TK_ERASE;
          tok_in.value     = item_r.time_value;
          state_nxt        = S_CHK_ERASE;
        end
      end

      S_CHK_CMP: begin
        tok_in.vld = 1'b1;
        if (item_r.time_value >= rd_q_r.begin_v) begin
          tok_in.kind  = TK_FIND;
          tok_in.value = rd_q_r.end_v;
          state_nxt    = S_CHK_FIND;
        end else begin
          res_nxt.in_range = set_cnt_r != '0;
          tok_in.kind      = TK_ERASE;
          tok_in.value     = item_r.time_value;
          state_nxt        = S_CHK_ERASE;
        end
      end

      S_CHK_FIND: begin
        if (tok_out.vld) begin
          if (tok_out.hit || set_full) begin
            if (!tok_out.hit) res_nxt.status = ST_SET_FULL;
            cursor_nxt = cursor_inc;
            state_nxt  = S_CHK_RD;
          end else begin
            tok_in.vld   = 1'b1;
            tok_in.kind  = TK_PLACE;
            tok_in.value = tok_out.value;
            state_nxt    = S_CHK_PLACE;
          end
        end
      end

      S_CHK_PLACE: begin
        if (tok_out.vld) begin
          set_cnt_nxt = set_cnt_r + 1'b1;
          cursor_nxt  = cursor_inc;
          state_nxt   = S_CHK_RD;
        end
      end

      S_CHK_ERASE: begin
        if (tok_out.vld) begin
          if (tok_out.hit) set_cnt_nxt = set_cnt_r - 1'b1;
          rd_en     = 1'b1;
          ra        = cursor_r[PW-1:0];
          state_nxt = S_OUT_LD;
        end
      end

      S_OUT_LD: begin
        if (at_entry) begin
          res_nxt.next_begin = rd_q_r.begin_v;
          res_nxt.next_end   = rd_q_r.end_v;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cursor_r    <= '0;
      count_r     <= '0;
      set_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cursor_r    <= cursor_nxt;
      count_r     <= count_nxt;
      set_cnt_r   <= set_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    key_r      <= key_nxt;
  end

  // interval pool: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rd_q_r <= mem[ra];
  end

  assign tok_chain[0] = tok_in;

  for (genvar g = 0; g < OPEN_SET_DEPTH; g++) begin : g_cell
    ipt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .clr   (set_clr),
      .tok_i (tok_chain[g]),
      .tok_o (tok_chain[g+1])
    );
  end

  assign tok_out = tok_chain[OPEN_SET_DEPTH];

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= count_r) else $error("cursor beyond entry count");

  a_set_bound: assert property (@(posedge clk) disable iff (!rst_n)
    set_cnt_r <= SW'(OPEN_SET_DEPTH)) else $error("end set count overflow");

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r != S_IDLE))
    else $error("accepted item did not start work");

  a_tok_owner: assert property (@(posedge clk) disable iff (!rst_n)
    tok_out.vld |-> (state_r == S_CHK_FIND || state_r == S_CHK_PLACE ||
                     state_r == S_CHK_ERASE))
    else $error("token left cell row with no waiting state");

endmodule

// ----- sim/tb_top.sv -----
// testbench for the interval pool time filter: random command sequences checked against a predictor
`timescale 1ns / 100ps

module tb_top;
  import ipt_pkg::*;

  localparam int POOL_N = 256;
  localparam int SET_N  = 64;

  // pool and end-set predictor with a queue of expected results
  class pool_scoreboard;
    logic [63:0] pool_bg[POOL_N];
    logic [63:0] pool_en[POOL_N];
    int          pool_cnt;
    int          cur;
    logic [63:0] set_val[SET_N];
    bit          set_vld[SET_N];
    out_item_t   expected_q[$];
    int          errors;

    function new();
      pool_cnt = 0;
      cur = 0;
      errors = 0;
      foreach (set_vld[i]) set_vld[i] = 0;
    endfunction

    function bit set_add(logic [63:0] v);
      int slot;
      slot = -1;
      for (int i = 0; i < SET_N; i++) begin
        if (set_vld[i]) begin
          if (set_val[i] == v) return 1;
        end else if (slot < 0) begin
          slot = i;
        end
      end
      if (slot < 0) return 0;
      set_val[slot] = v;
      set_vld[slot] = 1;
      return 1;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      logic [63:0] b, e;
      int j;
      r = '0;
      case (it.cmd)
        CMD_ADD: begin
          if (!(cur < pool_cnt) || it.interval_begin > pool_en[cur]) begin
            if (pool_cnt >= POOL_N) begin
              r.status = ST_POOL_FULL;
            end else begin
              pool_bg[pool_cnt] = it.interval_begin;
              pool_en[pool_cnt] = it.interval_end;
              cur = pool_cnt;
              pool_cnt++;
            end
          end else begin
            if (it.interval_begin < pool_bg[cur]) pool_bg[cur] = it.interval_begin;
            if (it.interval_end > pool_en[cur]) pool_en[cur] = it.interval_end;
          end
        end
        CMD_FINISH: begin
          // stable insertion sort on begin
          for (int i = 1; i < pool_cnt; i++) begin
            b = pool_bg[i];
            e = pool_en[i];
            j = i;
            while (j > 0 && pool_bg[j-1] > b) begin
              pool_bg[j] = pool_bg[j-1];
              pool_en[j] = pool_en[j-1];
              j--;
            end
            pool_bg[j] = b;
            pool_en[j] = e;
          end
          cur = 0;
          foreach (set_vld[i]) set_vld[i] = 0;
        end
        CMD_CHECK: begin
          while (cur < pool_cnt && it.time_value >= pool_bg[cur]) begin
            if (!set_add(pool_en[cur])) r.status = ST_SET_FULL;
            cur++;
          end
          foreach (set_vld[i]) if (set_vld[i]) r.in_range = 1;
          foreach (set_vld[i]) if (set_vld[i] && set_val[i] == it.time_value) set_vld[i] = 0;
        end
        default: begin
          pool_cnt = 0;
          cur = 0;
          foreach (set_vld[i]) set_vld[i] = 0;
        end
      endcase
      if (cur < pool_cnt) begin
        r.next_begin = pool_bg[cur];
        r.next_end = pool_en[cur];
      end
      expected_q = {expected_q, r};
    endfunction

    function void check_result(out_item_t got);
      out_item_t x;
      if (expected_q.size() == 0) begin
        $error("result with no item outstanding: %p", got);
        errors++;
        return;
      end
      x = expected_q.pop_front();
      if (got.in_range !== x.in_range) begin
        $error("in_range expected %0d got %0d", x.in_range, got.in_range);
        errors++;
      end
      if (got.next_begin !== x.next_begin) begin
        $error("next_begin expected %h got %h", x.next_begin, got.next_begin);
        errors++;
      end
      if (got.next_end !== x.next_end) begin
        $error("next_end expected %h got %h", x.next_end, got.next_end);
        errors++;
      end
      if (got.status !== x.status) begin
        $error("status expected %0d got %0d", x.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_item;

  pool_scoreboard sb;
  bit  no_idle;
  int  sent;
  int  full_pool_runs;

  interval_pool_time_filter uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // unused fields carry random bits
  function automatic in_item_t mk(logic [1:0] c, logic [63:0] b, logic [63:0] e,
                                  logic [63:0] t);
    in_item_t it;
    it.cmd = c;
    it.interval_begin = (c == CMD_ADD) ? b : rnd64();
    it.interval_end = (c == CMD_ADD) ? e : rnd64();
    it.time_value = (c == CMD_CHECK) ? t : rnd64();
    return it;
  endfunction

  task automatic send(in_item_t it);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid = 0;
      repeat (g) @(negedge clk);
    end
    in_item = it;
    in_valid = 1;
    // stall only moves at rising edges, so a low stall here means the next edge accepts
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sb.note_input(it);
    sent++;
    @(negedge clk);
  endtask

  task automatic add(logic [63:0] b, logic [63:0] e);
    send(mk(CMD_ADD, b, e, 0));
  endtask

  task automatic chk(logic [63:0] t);
    send(mk(CMD_CHECK, 0, 0, t));
  endtask

  task automatic cmd_only(logic [1:0] c);
    send(mk(c, 0, 0, 0));
  endtask

  // ordinary run: a few intervals, finish, then checks at mostly rising times
  task automatic normal_run();
    logic [63:0] base, b, e, t;
    int n;
    if ($urandom_range(0, 1)) cmd_only(CMD_CLEAR);
    base = ($urandom_range(0, 3) == 0) ? rnd64() : 64'($urandom_range(0, 1000));
    b = base;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: b = b - 64'($urandom_range(0, 20));     // may merge into the current entry
        1: b = b + 64'($urandom_range(0, 5));
        default: b = b + 64'($urandom_range(1, 60));
      endcase
      e = ($urandom_range(0, 9) == 0) ? b - 64'($urandom_range(0, 3))
                                      : b + 64'($urandom_range(0, 40));
      add(b, e);
      if ($urandom_range(0, 7) == 0) chk(b);
    end
    cmd_only(CMD_FINISH);
    t = base - 64'($urandom_range(0, 10));
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      // land on an open end now and then so it is removed
      if ($urandom_range(0, 2) == 0 && sb.cur > 0 && sb.cur <= sb.pool_cnt)
        t = sb.pool_en[sb.cur-1];
      else
        t = t + 64'($urandom_range(0, 40));
      chk(t);
    end
  endtask

  // more distinct ends than the set holds
  task automatic set_overflow_run();
    int n;
    cmd_only(CMD_CLEAR);
    n = $urandom_range(66, 80);
    for (int i = 0; i < n; i++) add(64'(i * 4), 64'(i * 4 + 1));
    cmd_only(CMD_FINISH);
    chk(64'($urandom_range(0, 100)));
    chk(64'd400);
    chk(64'd1005);
  endtask

  // fill the pool and push past it
  task automatic pool_overflow_run();
    cmd_only(CMD_CLEAR);
    for (int i = 0; i < POOL_N + 3; i++) add(64'(3 * (POOL_N + 3 - i)) + 64'd10, 64'd2);
    cmd_only(CMD_FINISH);
    chk(64'd30);
    chk(64'hffff_ffff_ffff_ffff);
  endtask

  task automatic noise_run();
    for (int i = 0; i < 5; i++)
      send(mk(2'($urandom_range(0, 3)), rnd64(), rnd64(), rnd64()));
  endtask

  // downstream stall pattern
  initial begin
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (no_idle) out_stall = 0;
      else if (out_stall) out_stall = ($urandom_range(0, 9) < 6);
      else out_stall = ($urandom_range(0, 9) < 3);
      if (!no_idle && $urandom_range(0, 199) == 0) begin
        out_stall = 1;
        repeat ($urandom_range(20, 80)) @(negedge clk);
        out_stall = 0;
      end
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);

  initial begin
    #40_000_000;
    $display("interval_pool_time_filter regression: fail");
    $finish;
  end

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_item = '0;
    no_idle = 0;
    sent = 0;
    full_pool_runs = 0;
    repeat (11) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed corners
    chk(64'd0);                               // check on an empty pool
    cmd_only(CMD_FINISH);                     // finish on an empty pool
    add(64'd0, 64'd0);
    add(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    add(64'd5, 64'd9);                        // merge takes the smaller begin
    add(64'd100, 64'd200);
    add(64'd150, 64'd300);                    // merge, end stays all ones
    add(64'd100, 64'd50);                     // merges into the same entry, begin stays 5
    add(64'd100, 64'd300);                    // merge, end already all ones
    cmd_only(CMD_FINISH);
    chk(64'd0);
    chk(64'd100);                             // opens the all-ones end of the second entry
    chk(64'd300);                             // no open end at 300, nothing removed
    chk(64'hffff_ffff_ffff_ffff);
    chk(64'hffff_ffff_ffff_ffff);
    add(64'd7, 64'd8);                        // cursor past the pool appends
    chk(64'd8);
    cmd_only(CMD_CLEAR);
    add(64'hffff_ffff_ffff_fff0, 64'd1);
    cmd_only(CMD_FINISH);
    chk(64'hffff_ffff_ffff_fff0);
    cmd_only(CMD_CLEAR);

    while (sent < 1550) begin
      no_idle = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 29))
        0, 1, 2: noise_run();
        3: set_overflow_run();
        4: begin
          if (full_pool_runs < 1) begin
            full_pool_runs++;
            pool_overflow_run();
          end else begin
            normal_run();
          end
        end
        default: normal_run();
      endcase
    end
    in_valid = 0;
    no_idle = 0;

    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (sb.errors == 0) begin
      $display("interval_pool_time_filter regression: pass");
    end else begin
      $display("interval_pool_time_filter regression: fail");
    end
    $finish;
  end

endmodule
